FILE: rtl/core/fci_pkg.sv
// Shared constants, codes and controller/datapath interface types for the flash command interface.
package fci_pkg;

    localparam int ADDRESS_BITS_DEF = 20;
    localparam int BLOCK_BITS_DEF   = 16;

    localparam int ADDR_FIELD_W = 20;
    localparam int BYTE_W       = 8;
    localparam int S_TDATA_W    = 32;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_OK  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_CODE = 2'd1;

    localparam logic [BYTE_W-1:0] CMD_READ_ARRAY  = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_READ_STATUS = 8'h70;
    localparam logic [BYTE_W-1:0] CMD_READ_ID     = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_PROGRAM     = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_ERASE       = 8'h20;
    localparam logic [BYTE_W-1:0] CMD_CONFIRM     = 8'hD0;

    localparam logic [BYTE_W-1:0] MAKER_CODE        = 8'h89;
    localparam logic [BYTE_W-1:0] DEVICE_CODE_RESET = 8'hA2;
    localparam logic [BYTE_W-1:0] ERASED_BYTE       = 8'hFF;

    localparam logic [BYTE_W-1:0] ST_READY     = 8'h80;
    localparam logic [BYTE_W-1:0] ST_ERASE_ERR = 8'h20;
    localparam logic [BYTE_W-1:0] ST_PROG_ERR  = 8'h10;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_MEM,
        OUT_IDENT,
        OUT_STATUS
    } out_sel_t;

    typedef struct packed {
        logic              accept;
        logic              load_out;
        out_sel_t          out_sel;
        logic [BYTE_W-1:0] status_byte;
        logic              mem_write;
        logic              fill;
        logic              sweep_step;
        logic              sweep_erase;
    } dp_cmd_t;

    typedef struct packed {
        logic              op_write;
        logic [BYTE_W-1:0] data_byte;
        logic              voltage_ok;
        logic              out_free;
        logic              clear_last;
        logic              erase_last;
    } dp_status_t;

endpackage

FILE: rtl/core/fci_controller.sv
// Command decoder and sequencing state machine for the flash command interface.
module fci_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fci_pkg::dp_status_t status,
    output fci_pkg::dp_cmd_t    cmd
);
    import fci_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ERASE
    } state_t;

    typedef enum logic [2:0] {
        MODE_ARRAY,
        MODE_STATUS,
        MODE_IDENT,
        MODE_PROG,
        MODE_ERASE
    } mode_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] status_reg, status_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        status_next     = status_reg;
        cmd             = '0;
        cmd.out_sel     = OUT_ZERO;
        cmd.status_byte = status_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_write  = 1'b1;
                cmd.fill       = 1'b1;
                cmd.sweep_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                    if (!status.op_write)
                    begin
                        unique case (mode_reg)
                            MODE_ARRAY: cmd.out_sel = OUT_MEM;
                            MODE_IDENT: cmd.out_sel = OUT_IDENT;
                            default:    cmd.out_sel = OUT_STATUS;
                        endcase
                    end
                    else if (mode_reg == MODE_PROG)
                    begin
                        mode_next = MODE_STATUS;
                        if (status.voltage_ok)
                        begin
                            cmd.mem_write = 1'b1;
                            status_next   = ST_READY;
                        end
                        else
                        begin
                            status_next = ST_READY | ST_PROG_ERR;
                        end
                    end
                    else if (mode_reg == MODE_ERASE)
                    begin
                        mode_next = MODE_STATUS;
                        if (status.data_byte != CMD_CONFIRM)
                        begin
                            status_next = ST_READY | ST_ERASE_ERR | ST_PROG_ERR;
                        end
                        else if (status.voltage_ok)
                        begin
                            status_next = ST_READY;
                            state_next  = ST_ERASE;
                        end
                        else
                        begin
                            status_next = ST_READY | ST_ERASE_ERR;
                        end
                    end
                    else
                    begin
                        unique case (status.data_byte)
                            CMD_READ_ARRAY:  mode_next = MODE_ARRAY;
                            CMD_READ_STATUS: mode_next = MODE_STATUS;
                            CMD_READ_ID:     mode_next = MODE_IDENT;
                            CMD_PROGRAM:     mode_next = MODE_PROG;
                            CMD_ERASE:       mode_next = MODE_ERASE;
                            default:         mode_next = mode_reg;
                        endcase
                    end
                end
            end
            ST_ERASE:
            begin
                cmd.mem_write   = 1'b1;
                cmd.fill        = 1'b1;
                cmd.sweep_step  = 1'b1;
                cmd.sweep_erase = 1'b1;
                if (status.erase_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            mode_reg   <= MODE_ARRAY;
            status_reg <= ST_READY;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: rtl/core/fci_datapath.sv
// Flash array memory, transaction registers, fill sweep, configuration and output register.
module fci_datapath #(
    parameter int ADDRESS_BITS = fci_pkg::ADDRESS_BITS_DEF,
    parameter int BLOCK_BITS   = fci_pkg::BLOCK_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fci_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fci_pkg::BYTE_W-1:0]        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fci_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fci_pkg::BYTE_W-1:0]        cfg_data,
    input  fci_pkg::dp_cmd_t                  cmd,
    output fci_pkg::dp_status_t               status
);
    import fci_pkg::*;

    localparam int DEPTH  = 1 << ADDRESS_BITS;
    localparam int BLK    = (BLOCK_BITS < ADDRESS_BITS) ? BLOCK_BITS : ADDRESS_BITS;
    localparam logic [ADDRESS_BITS-1:0] BLOCK_MASK = ADDRESS_BITS'((64'd1 << BLK) - 64'd1);
    localparam logic [ADDRESS_BITS-1:0] ALL_ONES   = '1;

    logic [BYTE_W-1:0]       mem [DEPTH];

    logic                    op_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [BYTE_W-1:0]       data_reg;
    logic [BYTE_W-1:0]       rd_data_reg;
    logic [ADDRESS_BITS-1:0] cnt_reg, cnt_next;
    logic                    vok_reg;
    logic [BYTE_W-1:0]       dev_code_reg;
    logic                    out_valid_reg;
    logic [BYTE_W-1:0]       out_data_reg;

    logic [ADDRESS_BITS-1:0] in_addr;
    logic [ADDRESS_BITS-1:0] sweep_addr;
    logic [ADDRESS_BITS-1:0] wr_addr;
    logic [BYTE_W-1:0]       wr_data;
    logic [BYTE_W-1:0]       out_value;

    assign in_addr    = ADDRESS_BITS'(s_tdata[ADDR_FIELD_W-1:0]);
    assign sweep_addr = cmd.sweep_erase ? ((addr_reg & ~BLOCK_MASK) | (cnt_reg & BLOCK_MASK))
                                        : cnt_reg;
    assign wr_addr    = cmd.fill ? sweep_addr : addr_reg;
    assign wr_data    = cmd.fill ? ERASED_BYTE : (rd_data_reg & data_reg);
    assign cnt_next   = cmd.sweep_erase ? ((cnt_reg + 1'b1) & BLOCK_MASK) : (cnt_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg <= mem[in_addr];
            op_reg      <= s_tuser;
            addr_reg    <= in_addr;
            data_reg    <= s_tdata[ADDR_FIELD_W +: BYTE_W];
        end
    end

    always_comb
    begin
        unique case (cmd.out_sel)
            OUT_ZERO:   out_value = '0;
            OUT_MEM:    out_value = rd_data_reg;
            OUT_IDENT:  out_value = addr_reg[0] ? dev_code_reg : MAKER_CODE;
            OUT_STATUS: out_value = cmd.status_byte;
            default:    out_value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= out_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            vok_reg       <= 1'b1;
            dev_code_reg  <= DEVICE_CODE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_step)
            begin
                cnt_reg <= cnt_next;
            end
            if (cfg_valid && cfg_index == CFG_VOLTAGE_OK)
            begin
                vok_reg <= cfg_data[0];
            end
            if (cfg_valid && cfg_index == CFG_DEVICE_CODE)
            begin
                dev_code_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign status.op_write   = op_reg;
    assign status.data_byte  = data_reg;
    assign status.voltage_ok = vok_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.clear_last = (cnt_reg == ALL_ONES);
    assign status.erase_last = ((cnt_reg & BLOCK_MASK) == BLOCK_MASK);

endmodule

FILE: rtl/core/flash_command_interface_top.sv
// A result is registered in the output register after its transaction is accepted, once that
// register is free; no new transaction is taken before then, so a wait on m_tready holds the flow.
// A confirmed block erase then fills 2**min(BLOCK_BITS, ADDRESS_BITS) bytes, one per cycle,
// set by the single write port of the array memory; no transaction is taken meanwhile.
// Reset (rst_n, async, active low) starts a fill of all 2**ADDRESS_BITS bytes with 0xFF,
// one per cycle, before the first transaction; configuration writes are taken at any time.
module flash_command_interface_top #(
    parameter int ADDRESS_BITS = fci_pkg::ADDRESS_BITS_DEF,
    parameter int BLOCK_BITS   = fci_pkg::BLOCK_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fci_pkg::S_TDATA_W-1:0]   s_tdata,   // address[19:0], write_data[27:20], zero
    input  logic                            s_tuser,   // opcode: 0 read, 1 write
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fci_pkg::BYTE_W-1:0]      m_tdata,   // read_data[7:0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fci_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fci_pkg::BYTE_W-1:0]      cfg_data
);
    import fci_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fci_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fci_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .BLOCK_BITS   (BLOCK_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
